FILE: hw/rtl/pfe_pkg.sv
package pfe_pkg;

    localparam int MAX_WIDTH   = 48;
    localparam int ARG_BITS    = 32;
    localparam int MAX_RESULTS = 48;
    localparam int NUM_DIGITS  = 11;

    localparam int WID_W  = 6;
    localparam int DIG_W  = 4;
    localparam int NDIG_W = $clog2(NUM_DIGITS + 1);
    localparam int IDX_W  = $clog2(NUM_DIGITS);
    localparam int CNT_W  = $clog2(ARG_BITS);

    localparam logic [1:0] RAD_HEX = 2'd0;
    localparam logic [1:0] RAD_DEC = 2'd1;
    localparam logic [1:0] RAD_OCT = 2'd2;

    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UN    = 8'h4E;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LC    = 8'h63;
    localparam logic [7:0] CH_LD    = 8'h64;
    localparam logic [7:0] CH_LH    = 8'h68;
    localparam logic [7:0] CH_LI    = 8'h69;
    localparam logic [7:0] CH_LL    = 8'h6C;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LO    = 8'h6F;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LU    = 8'h75;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef struct packed {
        logic                is_char;
        logic [7:0]          chr;
        logic [ARG_BITS-1:0] arg;
        logic [1:0]          radix;
        logic                sgn;
        logic                upper;
        logic                short_arg;
        logic                lj;
        logic                lz;
        logic [WID_W-1:0]    width;
    } t_cmd;

    typedef struct packed {
        logic              is_char;
        logic [7:0]        chr;
        logic              neg;
        logic [NDIG_W-1:0] ndig;
        logic              upper;
        logic              lj;
        logic              lz;
        logic [WID_W-1:0]  width;
    } t_fld;

    function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < DIG_W'(10)) begin
            digit_char = CH_ZERO + {4'b0, d};
        end else begin
            digit_char = base + {4'b0, d} - 8'd10;
        end
    endfunction

endpackage

FILE: hw/rtl/printf_format_engine.sv
// Integer printf formatter fed one format byte per input beat, with the argument riding on
// the beat that ends a conversion. Beats that only move the parser (percent sign, flags,
// width digits, modifiers, unknown conversions) leave the block ready and give no output.
// An echoed byte or a %c field passes the parser's command register, the converter's
// field register and the emitter's setup state before its first character; a numeric field
// first runs the serial digit converter (one digit shifted in per cycle for hex and octal,
// one argument bit per cycle through the add-3 digit chain for decimal), then a converter
// state counts the digits and the emitter's setup state sizes the field. The field leaves
// through a single output register at one character per cycle when the sink keeps up, at
// most 48 characters; the next beat is taken once the field's last character is loaded.
module printf_format_engine
    import pfe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_fmt_char,
    input  logic [ARG_BITS-1:0] i_arg_value,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_out_char,
    output logic                o_last_char
);

    logic             w_cmd_valid;
    t_cmd             w_cmd;
    logic             w_fld_valid;
    t_fld             w_fld;
    logic [IDX_W-1:0] w_rd_idx;
    logic [DIG_W-1:0] w_rd_digit;
    logic             w_done;

    pfe_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_fmt_char  (i_fmt_char),
        .i_arg_value (i_arg_value),
        .i_done      (w_done),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    pfe_conv u_conv (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .i_rd_idx    (w_rd_idx),
        .o_rd_digit  (w_rd_digit),
        .o_fld_valid (w_fld_valid),
        .o_fld       (w_fld)
    );

    pfe_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fld_valid (w_fld_valid),
        .i_fld       (w_fld),
        .o_rd_idx    (w_rd_idx),
        .i_rd_digit  (w_rd_digit),
        .o_done      (w_done),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

endmodule

FILE: hw/rtl/pfe_parser.sv
module pfe_parser
    import pfe_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_fmt_char,
    input  logic [ARG_BITS-1:0] i_arg_value,
    input  logic                i_done,
    output logic                o_cmd_valid,
    output t_cmd                o_cmd
);

    logic [2:0]       r_phase, n_phase;
    logic             r_lj, n_lj;
    logic             r_lz, n_lz;
    logic             r_long, n_long;
    logic             r_short, n_short;
    logic [WID_W-1:0] r_width, n_width;
    logic             r_busy, n_busy;
    logic             r_cmd_valid, n_cmd_valid;
    t_cmd             r_cmd, n_cmd;

    logic       v_accept;
    logic       v_p1, v_p2, v_p3;
    logic       v_digit, v_mod, v_clear, v_issue, v_known;
    logic [9:0] v_nw;

    always_comb begin
        n_phase     = r_phase;
        n_lj        = r_lj;
        n_lz        = r_lz;
        n_long      = r_long;
        n_short     = r_short;
        n_width     = r_width;
        n_busy      = r_busy;
        n_cmd_valid = 1'b0;
        n_cmd       = r_cmd;
        v_clear     = 1'b0;
        v_issue     = 1'b0;
        v_known     = 1'b1;
        v_accept    = i_in_valid && !r_busy;
        v_p1        = (r_phase == 3'd1);
        v_p2        = (r_phase == 3'd2);
        v_p3        = (r_phase == 3'd3);
        v_digit     = i_fmt_char inside {[CH_ZERO:CH_NINE]};
        v_mod       = i_fmt_char inside {CH_UF, CH_UN, CH_LL, CH_LH};
        v_nw        = ({4'b0, r_width} << 3) + ({4'b0, r_width} << 1) + {6'b0, i_fmt_char[3:0]};

        n_cmd.chr       = i_fmt_char;
        n_cmd.arg       = i_arg_value;
        n_cmd.is_char   = 1'b1;
        n_cmd.radix     = RAD_HEX;
        n_cmd.sgn       = 1'b0;
        n_cmd.upper     = 1'b0;
        n_cmd.short_arg = r_short && !r_long;
        n_cmd.lj        = 1'b0;
        n_cmd.lz        = 1'b0;
        n_cmd.width     = '0;

        if (v_accept) begin
            if (r_phase == 3'd0) begin
                if (i_fmt_char == CH_PCT) begin
                    n_phase = 3'd1;
                end else begin
                    v_issue = 1'b1;
                end
            end else if (v_p1 && i_fmt_char == CH_PCT) begin
                v_issue = 1'b1;
                v_clear = 1'b1;
            end else if (v_p1 && i_fmt_char == CH_MINUS) begin
                if (r_lj) begin
                    v_clear = 1'b1;
                end else begin
                    n_lj = 1'b1;
                end
            end else if (v_p1 && i_fmt_char == CH_ZERO) begin
                n_lz    = 1'b1;
                n_phase = 3'd2;
            end else if ((v_p1 || v_p2) && v_digit) begin
                n_width = (v_nw > 10'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : v_nw[WID_W-1:0];
                n_phase = 3'd2;
            end else if ((v_p1 || v_p2 || v_p3) && v_mod) begin
                if (i_fmt_char == CH_LL) begin
                    n_long = 1'b1;
                end
                if (i_fmt_char == CH_LH) begin
                    n_short = 1'b1;
                end
                n_phase = 3'd3;
            end else begin
                v_clear       = 1'b1;
                n_cmd.is_char = 1'b0;
                n_cmd.lj      = r_lj;
                n_cmd.lz      = r_lz;
                n_cmd.width   = r_width;
                case (i_fmt_char)
                    CH_UX: begin
                        n_cmd.upper = 1'b1;
                    end
                    CH_LX, CH_LP, CH_LN: begin
                        n_cmd.radix = RAD_HEX;
                    end
                    CH_LD, CH_LI: begin
                        n_cmd.radix = RAD_DEC;
                        n_cmd.sgn   = 1'b1;
                    end
                    CH_LU: begin
                        n_cmd.radix = RAD_DEC;
                    end
                    CH_LO: begin
                        n_cmd.radix = RAD_OCT;
                    end
                    CH_LC: begin
                        n_cmd.is_char = 1'b1;
                        n_cmd.lz      = 1'b0;
                        n_cmd.chr     = i_arg_value[7:0];
                    end
                    default: begin
                        v_known = 1'b0;
                    end
                endcase
                v_issue = v_known;
            end
            if (v_clear) begin
                n_phase = 3'd0;
                n_lj    = 1'b0;
                n_lz    = 1'b0;
                n_long  = 1'b0;
                n_short = 1'b0;
                n_width = '0;
            end
            if (v_issue) begin
                n_cmd_valid = 1'b1;
                n_busy      = 1'b1;
            end
        end
        if (i_done) begin
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 3'd0;
            r_lj        <= 1'b0;
            r_lz        <= 1'b0;
            r_long      <= 1'b0;
            r_short     <= 1'b0;
            r_width     <= '0;
            r_busy      <= 1'b0;
            r_cmd_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_lj        <= n_lj;
            r_lz        <= n_lz;
            r_long      <= n_long;
            r_short     <= n_short;
            r_width     <= n_width;
            r_busy      <= n_busy;
            r_cmd_valid <= n_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
    end

    assign o_in_ready  = !r_busy;
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd       = r_cmd;

endmodule

FILE: hw/rtl/pfe_conv.sv
module pfe_conv
    import pfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  t_cmd             i_cmd,
    input  logic [IDX_W-1:0] i_rd_idx,
    output logic [DIG_W-1:0] o_rd_digit,
    output logic             o_fld_valid,
    output t_fld             o_fld
);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RUN  = 2'd1;
    localparam logic [1:0] C_CNT  = 2'd2;

    localparam logic [ARG_BITS-1:0] SHORT_MASK = ARG_BITS'({16{1'b1}});

    logic [1:0]          r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic                r_fld_valid, n_fld_valid;
    logic [ARG_BITS-1:0] r_val, n_val;
    logic [1:0]          r_radix, n_radix;
    t_fld                r_fld, n_fld;
    logic [DIG_W-1:0]    r_dig [NUM_DIGITS];
    logic [DIG_W-1:0]    n_dig [NUM_DIGITS];

    logic [DIG_W-1:0]    v_adj [NUM_DIGITS];
    logic [ARG_BITS-1:0] v_arg;
    logic                v_sb;
    logic [NDIG_W-1:0]   v_ndig;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_fld_valid = 1'b0;
        n_val       = r_val;
        n_radix     = r_radix;
        n_fld       = r_fld;
        n_dig       = r_dig;
        v_arg       = i_cmd.short_arg ? (i_cmd.arg & SHORT_MASK) : i_cmd.arg;
        v_sb        = i_cmd.short_arg ? i_cmd.arg[15] : i_cmd.arg[ARG_BITS-1];
        v_ndig      = NDIG_W'(1);
        for (int i = 0; i < NUM_DIGITS; i++) begin
            v_adj[i] = (r_dig[i] >= DIG_W'(5)) ? r_dig[i] + DIG_W'(3) : r_dig[i];
        end
        for (int i = 1; i < NUM_DIGITS; i++) begin
            if (r_dig[i] != '0) begin
                v_ndig = NDIG_W'(i + 1);
            end
        end

        case (r_state)
            C_IDLE: begin
                if (i_cmd_valid) begin
                    n_fld.is_char = i_cmd.is_char;
                    n_fld.chr     = i_cmd.chr;
                    n_fld.upper   = i_cmd.upper;
                    n_fld.lj      = i_cmd.lj;
                    n_fld.lz      = i_cmd.lz;
                    n_fld.width   = i_cmd.width;
                    n_fld.ndig    = NDIG_W'(1);
                    n_fld.neg     = 1'b0;
                    if (i_cmd.is_char) begin
                        n_fld_valid = 1'b1;
                    end else begin
                        n_fld.neg = i_cmd.sgn && v_sb;
                        if (i_cmd.sgn && v_sb) begin
                            n_val = i_cmd.short_arg ? ((~v_arg + 1'b1) & SHORT_MASK)
                                                    : (~v_arg + 1'b1);
                        end else begin
                            n_val = v_arg;
                        end
                        n_radix = i_cmd.radix;
                        n_cnt   = (i_cmd.radix == RAD_DEC) ? CNT_W'(ARG_BITS - 1)
                                                           : CNT_W'(NUM_DIGITS - 1);
                        for (int i = 0; i < NUM_DIGITS; i++) begin
                            n_dig[i] = '0;
                        end
                        n_state = C_RUN;
                    end
                end
            end
            C_RUN: begin
                if (r_radix == RAD_DEC) begin
                    for (int i = 0; i < NUM_DIGITS; i++) begin
                        if (i == 0) begin
                            n_dig[i] = {v_adj[i][DIG_W-2:0], r_val[ARG_BITS-1]};
                        end else begin
                            n_dig[i] = {v_adj[i][DIG_W-2:0], v_adj[i-1][DIG_W-1]};
                        end
                    end
                    n_val = r_val << 1;
                end else begin
                    for (int i = 0; i < NUM_DIGITS - 1; i++) begin
                        n_dig[i] = r_dig[i+1];
                    end
                    if (r_radix == RAD_HEX) begin
                        n_dig[NUM_DIGITS-1] = r_val[3:0];
                        n_val               = r_val >> 4;
                    end else begin
                        n_dig[NUM_DIGITS-1] = {1'b0, r_val[2:0]};
                        n_val               = r_val >> 3;
                    end
                end
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = C_CNT;
                end
            end
            C_CNT: begin
                n_fld.ndig  = v_ndig;
                n_fld_valid = 1'b1;
                n_state     = C_IDLE;
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= C_IDLE;
            r_cnt       <= '0;
            r_fld_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fld_valid <= n_fld_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val   <= n_val;
        r_radix <= n_radix;
        r_fld   <= n_fld;
        r_dig   <= n_dig;
    end

    assign o_rd_digit  = (i_rd_idx < IDX_W'(NUM_DIGITS)) ? r_dig[i_rd_idx] : '0;
    assign o_fld_valid = r_fld_valid;
    assign o_fld       = r_fld;

endmodule

FILE: hw/rtl/pfe_emit.sv
module pfe_emit
    import pfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fld_valid,
    input  t_fld             i_fld,
    output logic [IDX_W-1:0] o_rd_idx,
    input  logic [DIG_W-1:0] i_rd_digit,
    output logic             o_done,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic [7:0]       o_out_char,
    output logic             o_last_char
);

    localparam logic [1:0] E_IDLE  = 2'd0;
    localparam logic [1:0] E_SETUP = 2'd1;
    localparam logic [1:0] E_RUN   = 2'd2;

    logic [1:0]       r_state, n_state;
    logic             r_ovalid, n_ovalid;
    logic [WID_W-1:0] r_p, n_p;
    t_fld             r_fld, n_fld;
    logic [WID_W-1:0] r_pre, n_pre;
    logic [WID_W-1:0] r_bstart, n_bstart;
    logic [WID_W-1:0] r_bend, n_bend;
    logic [WID_W-1:0] r_lastp, n_lastp;
    logic [IDX_W-1:0] r_didx, n_didx;
    logic [7:0]       r_ochar, n_ochar;
    logic             r_olast, n_olast;

    logic [WID_W-1:0] v_blen, v_actual, v_pad, v_tot, v_pre;
    logic             v_adv, v_last, v_body;
    logic [7:0]       v_char;

    always_comb begin
        v_blen   = r_fld.is_char ? WID_W'(1) : WID_W'(r_fld.ndig);
        v_actual = v_blen + WID_W'(r_fld.neg);
        v_pad    = (r_fld.width > v_actual) ? r_fld.width - v_actual : '0;
        v_tot    = (r_fld.width > v_actual) ? r_fld.width : v_actual;
        v_tot    = (v_tot > WID_W'(MAX_RESULTS)) ? WID_W'(MAX_RESULTS) : v_tot;
        v_pre    = r_fld.lj ? '0 : v_pad;

        v_adv  = (r_state == E_RUN) && (!r_ovalid || i_out_ready);
        v_last = (r_p == r_lastp);
        v_body = 1'b0;
        if (r_fld.neg && r_fld.lz && r_p == '0) begin
            v_char = CH_MINUS;
        end else if (r_fld.neg && !r_fld.lz && r_p == r_pre) begin
            v_char = CH_MINUS;
        end else if (r_p < r_bstart) begin
            v_char = r_fld.lz ? CH_ZERO : CH_SPACE;
        end else if (r_p < r_bend) begin
            v_body = 1'b1;
            v_char = r_fld.is_char ? r_fld.chr : digit_char(i_rd_digit, r_fld.upper);
        end else begin
            v_char = CH_SPACE;
        end

        n_state  = r_state;
        n_ovalid = r_ovalid;
        n_p      = r_p;
        n_fld    = r_fld;
        n_pre    = r_pre;
        n_bstart = r_bstart;
        n_bend   = r_bend;
        n_lastp  = r_lastp;
        n_didx   = r_didx;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        o_done   = 1'b0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            E_IDLE: begin
                if (i_fld_valid) begin
                    n_fld   = i_fld;
                    n_state = E_SETUP;
                end
            end
            E_SETUP: begin
                n_pre    = v_pre;
                n_bstart = v_pre + WID_W'(r_fld.neg);
                n_bend   = v_pre + WID_W'(r_fld.neg) + v_blen;
                n_lastp  = v_tot - 1'b1;
                n_didx   = IDX_W'(r_fld.ndig - 1'b1);
                n_p      = '0;
                n_state  = E_RUN;
            end
            E_RUN: begin
                if (v_adv) begin
                    n_ovalid = 1'b1;
                    n_ochar  = v_char;
                    n_olast  = v_last;
                    n_p      = r_p + 1'b1;
                    if (v_body) begin
                        n_didx = r_didx - 1'b1;
                    end
                    if (v_last) begin
                        o_done  = 1'b1;
                        n_state = E_IDLE;
                    end
                end
            end
            default: begin
                n_state = E_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= E_IDLE;
            r_ovalid <= 1'b0;
            r_p      <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_p      <= n_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fld    <= n_fld;
        r_pre    <= n_pre;
        r_bstart <= n_bstart;
        r_bend   <= n_bend;
        r_lastp  <= n_lastp;
        r_didx   <= n_didx;
        r_ochar  <= n_ochar;
        r_olast  <= n_olast;
    end

    assign o_rd_idx    = r_didx;
    assign o_out_valid = r_ovalid;
    assign o_out_char  = r_ochar;
    assign o_last_char = r_olast;

    a_done_shows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> o_out_valid && o_last_char)
        else $error("final beat of a field was not presented");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_RUN) |-> (r_p <= r_lastp))
        else $error("character position ran past the end of the field");

    a_len_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_RUN) |-> (r_lastp < WID_W'(MAX_RESULTS)))
        else $error("field longer than the result limit");

    a_digit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_RUN && v_body && !r_fld.is_char) |-> (r_didx < IDX_W'(NUM_DIGITS)))
        else $error("digit index out of range");

endmodule
